// ===== src/trapezoid_fuzzy_membership_macros.svh =====
`ifndef TRAPEZOID_FUZZY_MEMBERSHIP_MACROS_SVH
`define TRAPEZOID_FUZZY_MEMBERSHIP_MACROS_SVH

// clocked property with asynchronous active-low reset
`define TFM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tfm assertion failed");

// same-cycle implication
`define TFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `TFM_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ===== src/tfm_pkg.sv =====
`timescale 1ns / 1ps

package tfm_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int DEG_W       = 7;
  localparam int CFG_IDX_W   = 3;

  localparam logic [DEG_W-1:0] DEG_FULL = 7'd100;
  localparam logic [DEG_W-1:0] DEG_NONE = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_FOOT,
    CFG_LEFT_CORE,
    CFG_RIGHT_CORE,
    CFG_RIGHT_FOOT,
    CFG_LEFT_OPEN,
    CFG_RIGHT_OPEN
  } cfg_idx_e;

  typedef struct packed {
    logic             shoulder;
    logic [DEG_W-1:0] degree;
  } cls_t;

endpackage

// ===== src/tfm_front.sv =====
`timescale 1ns / 1ps

module tfm_front #(
  parameter int DATA_WIDTH = tfm_pkg::DATA_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tfm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]           cfg_wdata_i,
  input  logic signed [DATA_WIDTH-1:0]    sample_i,
  output tfm_pkg::cls_t                   cls_o,
  output logic [DATA_WIDTH-1:0]           num_o,
  output logic [DATA_WIDTH-1:0]           den_o
);

  logic signed [DATA_WIDTH-1:0] lf_q, lc_q, rc_q, rf_q;
  logic                         lo_q, ro_q;
  logic                         full_deg, fall_side, rise_ok, fall_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_q <= '0;
      lc_q <= '0;
      rc_q <= '0;
      rf_q <= '0;
      lo_q <= 1'b0;
      ro_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfm_pkg::CFG_LEFT_FOOT:  lf_q <= cfg_wdata_i;
        tfm_pkg::CFG_LEFT_CORE:  lc_q <= cfg_wdata_i;
        tfm_pkg::CFG_RIGHT_CORE: rc_q <= cfg_wdata_i;
        tfm_pkg::CFG_RIGHT_FOOT: rf_q <= cfg_wdata_i;
        tfm_pkg::CFG_LEFT_OPEN:  lo_q <= cfg_wdata_i[0];
        tfm_pkg::CFG_RIGHT_OPEN: ro_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    full_deg  = 1'b0;
    fall_side = 1'b0;
    if (lo_q) begin
      if (sample_i <= rc_q) full_deg = 1'b1;
      else fall_side = 1'b1;
    end else if (ro_q) begin
      if (sample_i >= lc_q) full_deg = 1'b1;
    end else if (sample_i >= lc_q && sample_i <= rc_q) begin
      full_deg = 1'b1;
    end else if (sample_i > rc_q) begin
      fall_side = 1'b1;
    end
  end

  assign rise_ok = (sample_i > lf_q) && (sample_i < lc_q);
  assign fall_ok = (sample_i > rc_q) && (sample_i < rf_q);

  assign cls_o.shoulder = !full_deg && (fall_side ? fall_ok : rise_ok);
  assign cls_o.degree   = full_deg ? tfm_pkg::DEG_FULL : tfm_pkg::DEG_NONE;

  assign num_o = fall_side ? $unsigned(rf_q - sample_i) : $unsigned(sample_i - lf_q);
  assign den_o = fall_side ? $unsigned(rf_q - rc_q) : $unsigned(lc_q - lf_q);

endmodule

// ===== src/tfm_queue.sv =====
`timescale 1ns / 1ps

module tfm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tfm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ===== src/tfm_back.sv =====
`timescale 1ns / 1ps

module tfm_back #(
  parameter int DATA_WIDTH = tfm_pkg::DATA_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  tfm_pkg::cls_t             in_cls_i,
  input  logic [DATA_WIDTH-1:0]     in_num_i,
  input  logic [DATA_WIDTH-1:0]     in_den_i,
  output logic                      in_take_o,
  output logic                      res_valid_o,
  output logic [tfm_pkg::DEG_W-1:0] res_degree_o,
  input  logic                      res_pop_i
);

  localparam int QB = tfm_pkg::DEG_W;
  localparam int NW = DATA_WIDTH + QB;

  logic [QB:0]             vld_q, vld_d;
  logic [NW-1:0]           rem_q [QB+1];
  logic [NW-1:0]           rem_d [QB+1];
  logic [NW-1:0]           dsh   [QB+1];
  logic [DATA_WIDTH-1:0]   den_q [QB+1];
  logic [DATA_WIDTH-1:0]   den_d [QB+1];
  logic [QB-1:0]           quo_q [QB+1];
  logic [QB-1:0]           quo_d [QB+1];
  tfm_pkg::cls_t           cls_q [QB+1];
  tfm_pkg::cls_t           cls_d [QB+1];

  logic                    adv, round_up, out_vld_q;
  logic [QB-1:0]           out_deg_q, deg_d;

  assign adv       = !out_vld_q || res_pop_i;
  assign in_take_o = adv && in_valid_i;

  always_comb begin
    vld_d[0] = in_valid_i;
    rem_d[0] = NW'(in_num_i) * NW'(tfm_pkg::DEG_FULL);
    den_d[0] = in_den_i;
    quo_d[0] = '0;
    cls_d[0] = in_cls_i;
    dsh[0]   = '0;
    for (int i = 1; i <= QB; i++) begin
      dsh[i]   = NW'(den_q[i-1]) << (QB - i);
      vld_d[i] = vld_q[i-1];
      den_d[i] = den_q[i-1];
      cls_d[i] = cls_q[i-1];
      if (rem_q[i-1] >= dsh[i]) begin
        rem_d[i] = rem_q[i-1] - dsh[i];
        quo_d[i] = quo_q[i-1] | (QB'(1) << (QB - i));
      end else begin
        rem_d[i] = rem_q[i-1];
        quo_d[i] = quo_q[i-1];
      end
    end
  end

  assign round_up = {rem_q[QB][DATA_WIDTH-1:0], 1'b0} >= {1'b0, den_q[QB]};
  assign deg_d    = cls_q[QB].shoulder ? quo_q[QB] + QB'(round_up) : cls_q[QB].degree;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= QB; i++) begin
        rem_q[i] <= rem_d[i];
        den_q[i] <= den_d[i];
        quo_q[i] <= quo_d[i];
        cls_q[i] <= cls_d[i];
      end
      out_deg_q <= deg_d;
    end
  end

  assign res_valid_o  = out_vld_q;
  assign res_degree_o = out_deg_q;

endmodule

// ===== src/trapezoid_fuzzy_membership.sv =====
`timescale 1ns / 1ps

// Trapezoidal membership grader: each pushed sample yields one degree in
// hundredths (0..100, rounded half up). At full rate one sample is taken
// and one result leaves per cycle, while full is low and pop is held. An
// accepted sample passes the queue and then the back end: a stage that
// forms 100 times the shoulder offset, seven restoring divide stages (one
// quotient bit each), and the result register that holds the rounded
// degree. A queue of QUEUE_DEPTH entries sits between the classifier and
// the divide pipeline, so full rises only when the result side has been
// stalled long enough to fill it.
module trapezoid_fuzzy_membership #(
  parameter int DATA_WIDTH  = tfm_pkg::DATA_WIDTH,
  parameter int QUEUE_DEPTH = tfm_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tfm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]           cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic signed [DATA_WIDTH-1:0]    sample_value_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [tfm_pkg::DEG_W-1:0]       degree_hundredths_o
);

  localparam int EW = $bits(tfm_pkg::cls_t) + 2 * DATA_WIDTH;

  tfm_pkg::cls_t         f_cls, q_cls;
  logic [DATA_WIDTH-1:0] f_num, f_den, q_num, q_den;
  logic [EW-1:0]         q_rdata;
  logic                  q_valid, q_take, res_valid;

  tfm_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_value_i),
    .cls_o       (f_cls),
    .num_o       (f_num),
    .den_o       (f_den)
  );

  tfm_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i ({f_cls, f_num, f_den}),
    .full_o  (full),
    .rd_i    (q_take),
    .rdata_o (q_rdata),
    .valid_o (q_valid)
  );

  assign {q_cls, q_num, q_den} = q_rdata;

  tfm_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_cls_i     (q_cls),
    .in_num_i     (q_num),
    .in_den_i     (q_den),
    .in_take_o    (q_take),
    .res_valid_o  (res_valid),
    .res_degree_o (degree_hundredths_o),
    .res_pop_i    (pop)
  );

  assign empty = !res_valid;

endmodule

// ===== src/tfm_checker.sv =====
`timescale 1ns / 1ps
`include "trapezoid_fuzzy_membership_macros.svh"

module tfm_checker #(
  parameter int QUEUE_DEPTH = tfm_pkg::QUEUE_DEPTH
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      push,
  input logic                      full,
  input logic                      pop,
  input logic                      empty,
  input logic [tfm_pkg::DEG_W-1:0] degree_hundredths_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + tfm_pkg::DEG_W + 3) + 1;

  logic [CW-1:0] cnt_q;
  logic          in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  `TFM_ASSERT_IMP(a_deg_range, clk_i, rst_ni, !empty, degree_hundredths_o <= tfm_pkg::DEG_FULL)
  `TFM_ASSERT_IMP(a_no_invented, clk_i, rst_ni, cnt_q == '0, empty)
  `TFM_ASSERT_IMP(a_full_busy, clk_i, rst_ni, full, cnt_q != '0)
  `TFM_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(degree_hundredths_o)))

endmodule

bind trapezoid_fuzzy_membership tfm_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tfm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .push                (push),
  .full                (full),
  .pop                 (pop),
  .empty               (empty),
  .degree_hundredths_o (degree_hundredths_o)
);

// ===== tb/sv/tfm_degree_checker.sv =====
`timescale 1ns / 1ps

module tfm_degree_checker
  import tfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic                  push,
  input  logic                  full,
  input  logic [DATA_WIDTH-1:0] sample_value_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [DEG_W-1:0]      degree_hundredths_o,
  output int                    mismatches_o,
  output int                    degrees_outstanding_o
);

  logic signed [DATA_WIDTH-1:0] left_foot, left_core, right_core, right_foot;
  logic                         left_open, right_open;
  logic [DEG_W-1:0]             pending_degrees [$];

  function automatic logic [DEG_W-1:0] shoulder_degree(input longint signed num,
                                                       input longint signed den);
    longint unsigned n, d;
    n = num;
    d = den;
    return DEG_W'((200 * n + d) / (2 * d));
  endfunction

  function automatic logic [DEG_W-1:0] rising_degree(input longint signed x,
                                                     input longint signed foot,
                                                     input longint signed core);
    if (x <= foot || x >= core) return DEG_NONE;
    return shoulder_degree(x - foot, core - foot);
  endfunction

  function automatic logic [DEG_W-1:0] falling_degree(input longint signed x,
                                                      input longint signed core,
                                                      input longint signed foot);
    if (x >= foot || x <= core) return DEG_NONE;
    return shoulder_degree(foot - x, foot - core);
  endfunction

  function automatic logic [DEG_W-1:0] predict_degree(input logic signed [DATA_WIDTH-1:0] x);
    longint signed xs, lf, lc, rc, rf;
    xs = x;
    lf = left_foot;
    lc = left_core;
    rc = right_core;
    rf = right_foot;
    if (left_open) return (xs <= rc) ? DEG_FULL : falling_degree(xs, rc, rf);
    if (right_open) return (xs >= lc) ? DEG_FULL : rising_degree(xs, lf, lc);
    if (xs >= lc && xs <= rc) return DEG_FULL;
    if (xs > rc) return falling_degree(xs, rc, rf);
    return rising_degree(xs, lf, lc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [DEG_W-1:0] want;
    if (!rst_ni) begin
      left_foot  <= '0;
      left_core  <= '0;
      right_core <= '0;
      right_foot <= '0;
      left_open  <= 1'b0;
      right_open <= 1'b0;
      pending_degrees.delete();
      mismatches_o          <= 0;
      degrees_outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LEFT_FOOT:  left_foot  <= cfg_wdata_i;
          CFG_LEFT_CORE:  left_core  <= cfg_wdata_i;
          CFG_RIGHT_CORE: right_core <= cfg_wdata_i;
          CFG_RIGHT_FOOT: right_foot <= cfg_wdata_i;
          CFG_LEFT_OPEN:  left_open  <= cfg_wdata_i[0];
          CFG_RIGHT_OPEN: right_open <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (push && !full) pending_degrees.push_back(predict_degree(sample_value_i));
      if (pop && !empty) begin
        if (pending_degrees.size() == 0) begin
          $error("degree_hundredths: expected none, actual %0d", degree_hundredths_o);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = pending_degrees.pop_front();
          if (degree_hundredths_o !== want) begin
            $error("degree_hundredths: expected %0d, actual %0d", want, degree_hundredths_o);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      degrees_outstanding_o <= pending_degrees.size();
    end
  end

endmodule

// ===== tb/sv/tb_trapezoid_fuzzy_membership.sv =====
`timescale 1ns / 1ps

module tb_trapezoid_fuzzy_membership;
  import tfm_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 115;
  localparam int ONE          = 65536;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam logic signed [DATA_WIDTH-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_WIDTH-1:0] S_MAX = 32'sh7fff_ffff;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i      = '0;
  logic [DATA_WIDTH-1:0]        cfg_wdata_i    = '0;
  logic                         push           = 1'b0;
  logic                         full;
  logic signed [DATA_WIDTH-1:0] sample_value_i = '0;
  logic                         empty;
  logic                         pop            = 1'b0;
  logic [DEG_W-1:0]             degree_hundredths_o;

  int mismatches;
  int outstanding;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  always #6 clk_i = ~clk_i;

  trapezoid_fuzzy_membership dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .push,
    .full,
    .sample_value_i,
    .empty,
    .pop,
    .degree_hundredths_o
  );

  tfm_degree_checker degree_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .push,
    .full,
    .sample_value_i,
    .empty,
    .pop,
    .degree_hundredths_o,
    .mismatches_o          (mismatches),
    .degrees_outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= quiet || ($urandom_range(99, 0) >= 19);
      end
    end
  end

  task automatic offer(input logic signed [DATA_WIDTH-1:0] value);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99, 0) < 19) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    sample_value_i <= value;
    do @(posedge clk_i); while (full);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    @(posedge clk_i);
  endtask

  task automatic program_trapezoid(input logic signed [DATA_WIDTH-1:0] lf,
                                   input logic signed [DATA_WIDTH-1:0] lc,
                                   input logic signed [DATA_WIDTH-1:0] rc,
                                   input logic signed [DATA_WIDTH-1:0] rf,
                                   input logic lo, input logic ro);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LEFT_FOOT;
    cfg_wdata_i <= lf;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LEFT_CORE;
    cfg_wdata_i <= lc;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RIGHT_CORE;
    cfg_wdata_i <= rc;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RIGHT_FOOT;
    cfg_wdata_i <= rf;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LEFT_OPEN;
    cfg_wdata_i <= (DATA_WIDTH'($urandom) & ~DATA_WIDTH'(1)) | DATA_WIDTH'(lo);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RIGHT_OPEN;
    cfg_wdata_i <= (DATA_WIDTH'($urandom) & ~DATA_WIDTH'(1)) | DATA_WIDTH'(ro);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SPARE;
    cfg_wdata_i <= DATA_WIDTH'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int phase, input int count);
    logic signed [DATA_WIDTH-1:0] pts [4];
    logic signed [DATA_WIDTH-1:0] swap;
    longint signed pick;
    int shift;
    logic lo, ro;
    shift = $urandom_range(31, 0);
    foreach (pts[i]) pts[i] = $signed($urandom) >>> shift;
    // every fourth phase keeps the breakpoints out of order
    if (phase % 4 != 3) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3 - i; j++)
          if (pts[j] > pts[j+1]) begin
            swap = pts[j];
            pts[j] = pts[j+1];
            pts[j+1] = swap;
          end
    end
    lo = (phase < 4) ? phase[0] : 1'($urandom_range(1, 0));
    ro = (phase < 4) ? phase[1] : 1'($urandom_range(1, 0));
    program_trapezoid(pts[0], pts[1], pts[2], pts[3], lo, ro);
    for (int n = 0; n < count; n++) begin
      if (phase == 7 && n == count / 2) settle();
      case ($urandom_range(9, 0))
        0: pick = $signed($urandom);
        1: pick = longint'(pts[$urandom_range(3, 0)]) + int'($urandom_range(2, 0)) - 1;
        default: pick = longint'(pts[$urandom_range(3, 0)])
                        + longint'($signed($urandom) >>> $urandom_range(31, shift));
      endcase
      if (pick < S_MIN) pick = S_MIN;
      if (pick > S_MAX) pick = S_MAX;
      offer(pick[DATA_WIDTH-1:0]);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_trapezoid(-10 * ONE, -2 * ONE, 3 * ONE, 12 * ONE + ONE / 2, 1'b0, 1'b0);
    offer(S_MIN);
    offer(-10 * ONE);
    offer(-10 * ONE + 1);
    offer(-6 * ONE);
    offer(-2 * ONE - 1);
    offer(-2 * ONE);
    offer(0);
    offer(3 * ONE);
    offer(3 * ONE + 1);
    offer(12 * ONE);
    offer(12 * ONE + ONE / 2);
    offer(S_MAX);
    settle();

    // rounding ties (exactly half a hundredth) on both shoulders
    program_trapezoid(0, 200, 300, 500, 1'b0, 1'b0);
    offer(1);
    offer(199);
    offer(401);
    settle();

    program_trapezoid(S_MIN, -1, 0, S_MAX, 1'b1, 1'b0);
    offer(S_MIN);
    offer(1);
    offer(S_MAX - 1);
    settle();

    program_trapezoid(S_MIN, -1, 0, S_MAX, 1'b0, 1'b1);
    offer(S_MIN + 1);
    offer(-2);
    offer(S_MAX);
    settle();

    // both open, right foot inside the core
    program_trapezoid(5 * ONE, -ONE, 2 * ONE, ONE, 1'b1, 1'b1);
    offer(0);
    offer(3 * ONE);
    offer(S_MIN);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 3);
      if (p == 5) hold_request = 1'b1;
      run_phase(p, PHASE_ITEMS);
      settle();
    end
    quiet = 1'b0;

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tfm_pkg.sv
src/tfm_front.sv
src/tfm_queue.sv
src/tfm_back.sv
src/trapezoid_fuzzy_membership.sv
src/tfm_checker.sv
tb/sv/tfm_degree_checker.sv
tb/sv/tb_trapezoid_fuzzy_membership.sv
